FILE: src/brle_pkg.sv
// Shared types and constants for the bit-flag RLE compressor.
`timescale 1ns / 1ps

package brle_pkg;

  // Result stream codes
  localparam logic [1:0] SEL_DATA   = 2'd0;
  localparam logic [1:0] SEL_RLE    = 2'd1;
  localparam logic [1:0] SEL_POINTS = 2'd2;

  // Bit position codes: start of a byte, and "byte just completed"
  localparam logic [3:0] POS_START = 4'd7;
  localparam logic [3:0] POS_EMPTY = 4'd8;

  // Results per word and output queue depth
  localparam int MAX_RES = 3;
  localparam int Q_DEPTH = 4;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [1:0] stream_select;
    logic [7:0] out_byte;
    logic       last_of_run;
  } brle_res_t;

  // All results caused by one input word
  typedef struct packed {
    brle_res_t [MAX_RES-1:0] res;
    logic [1:0]              cnt;
  } brle_bundle_t;

  // Core status seen by the top level
  typedef struct packed {
    logic       first_pixel_pending;
    logic [1:0] res_count;
  } brle_core_status_t;

  // Output queue status
  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
    logic               room;
  } brle_q_status_t;

endpackage

FILE: src/brle_in_if.sv
// Input channel: one picture byte per word.
`timescale 1ns / 1ps

interface brle_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       end_of_image;

  modport source (output valid, output pixel_byte, output end_of_image, input ready);
  modport sink (input valid, input pixel_byte, input end_of_image, output ready);
endinterface

FILE: src/brle_out_if.sv
// Output channel: one tagged compressed byte per word.
`timescale 1ns / 1ps

interface brle_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] stream_select;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output stream_select, output out_byte,
                  output last_of_run, input ready);
  modport sink (input valid, input stream_select, input out_byte,
                input last_of_run, output ready);
endinterface

FILE: src/bitflag_rle_compressor.sv
// Top level of the two-level bit-flag RLE compressor.
`timescale 1ns / 1ps

// Takes one picture byte per cycle and emits tagged data, rle-flag and points
// bytes on the results channel, one word per cycle while the downstream is
// ready. A byte that causes at most one result sustains one byte per cycle
// while the downstream is ready; one that causes two or three results (flag
// byte or points byte completion, end-of-image flush) enters the four-entry
// output queue, and the input stalls while more than one word is queued. Ready
// does not depend on the downstream ready. State returns to reset after a byte
// marked end_of_image, so the next byte starts a new image.
module bitflag_rle_compressor
  import brle_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  brle_in_if.sink    pixels,
  brle_out_if.source results
);

  brle_bundle_t      bundle;
  brle_core_status_t core_st;
  brle_q_status_t    q_st;
  logic              accept;

  assign pixels.ready = q_st.room;
  assign accept       = pixels.valid && pixels.ready;

  brle_core u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .pixel_byte   (pixels.pixel_byte),
    .end_of_image (pixels.end_of_image),
    .bundle       (bundle),
    .status       (core_st)
  );

  brle_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .push    (accept),
    .bundle  (bundle),
    .results (results),
    .status  (q_st)
  );

  // Queue never overflows
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_st.count <= Q_CNT_W'(Q_DEPTH))
    else $error("output queue overflow");

  // A word that makes results shows one on the next cycle
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    accept && (core_st.res_count != 2'd0) |=> results.valid)
    else $error("accepted results not presented");

  // First byte of an image always yields a data byte
  a_first_emits: assert property (@(posedge clk) disable iff (rst)
    accept && core_st.first_pixel_pending |-> core_st.res_count != 2'd0)
    else $error("first byte produced no result");

  // End of image returns the compressor to its start state
  a_eoi_restart: assert property (@(posedge clk) disable iff (rst)
    accept && pixels.end_of_image |=> core_st.first_pixel_pending)
    else $error("state not restarted after end of image");

endmodule

FILE: src/brle_core.sv
// Compressor state and the per-word step producing up to three results.
`timescale 1ns / 1ps

module brle_core
  import brle_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        pixel_byte,
  input  logic              end_of_image,
  output brle_bundle_t      bundle,
  output brle_core_status_t status
);

  typedef struct packed {
    logic       first_pixel_pending;
    logic [7:0] previous_pixel;
    logic [7:0] flag_accum;
    logic [3:0] flag_bit_pos;
    logic       first_flag_pending;
    logic [7:0] previous_flag_byte;
    logic [7:0] points_accum;
    logic [3:0] points_bit_pos;
  } state_t;

  typedef struct packed {
    state_t       st;
    brle_bundle_t out;
  } work_t;

  localparam state_t STATE_RESET = '{
    first_pixel_pending: 1'b1,
    previous_pixel:      8'd0,
    flag_accum:          8'd0,
    flag_bit_pos:        POS_START,
    first_flag_pending:  1'b1,
    previous_flag_byte:  8'd0,
    points_accum:        8'd0,
    points_bit_pos:      POS_START
  };

  state_t state;
  state_t state_next;
  work_t  w;

  // Append one result; words past the third are dropped
  function automatic work_t emit(work_t wi, logic [1:0] sel, logic [7:0] b);
    work_t wo;
    wo = wi;
    if (wo.out.cnt < 2'(MAX_RES)) begin
      wo.out.res[wo.out.cnt] = '{stream_select: sel, out_byte: b, last_of_run: 1'b0};
      wo.out.cnt = wo.out.cnt + 2'd1;
    end
    return wo;
  endfunction

  // Second level: a finished flag byte
  function automatic work_t save_flag(work_t wi, logic [7:0] flag);
    work_t wo;
    wo = wi;
    if (wo.st.first_flag_pending) begin
      wo = emit(wo, SEL_RLE, flag);
      wo.st.first_flag_pending = 1'b0;
    end else begin
      wo.st.points_bit_pos = wo.st.points_bit_pos - 4'd1;
      if (flag != wo.st.previous_flag_byte) begin
        wo = emit(wo, SEL_RLE, flag);
        wo.st.points_accum = wo.st.points_accum | (8'd1 << wo.st.points_bit_pos[2:0]);
      end
      if (wo.st.points_bit_pos == 4'd0) begin
        wo = emit(wo, SEL_POINTS, wo.st.points_accum);
        wo.st.points_accum   = 8'd0;
        wo.st.points_bit_pos = POS_EMPTY;
      end
    end
    wo.st.previous_flag_byte = flag;
    return wo;
  endfunction

  // First level, end-of-image flush and last-word marking
  always_comb begin
    w        = '0;
    w.st     = state;
    w.out    = '0;
    if (w.st.first_pixel_pending) begin
      w = emit(w, SEL_DATA, pixel_byte);
      w.st.first_pixel_pending = 1'b0;
    end else begin
      w.st.flag_bit_pos = w.st.flag_bit_pos - 4'd1;
      if (pixel_byte != w.st.previous_pixel) begin
        w = emit(w, SEL_DATA, pixel_byte);
        w.st.flag_accum = w.st.flag_accum | (8'd1 << w.st.flag_bit_pos[2:0]);
      end
      if (w.st.flag_bit_pos == 4'd0) begin
        w = save_flag(w, w.st.flag_accum);
        w.st.flag_accum   = 8'd0;
        w.st.flag_bit_pos = POS_EMPTY;
      end
    end
    w.st.previous_pixel = pixel_byte;

    if (end_of_image) begin
      if (w.st.flag_bit_pos != POS_EMPTY) begin
        w = save_flag(w, w.st.flag_accum);
      end
      if (w.st.points_bit_pos != POS_EMPTY) begin
        w = emit(w, SEL_POINTS, w.st.points_accum);
      end
      w.st = STATE_RESET;
    end

    if (w.out.cnt != 2'd0) begin
      w.out.res[w.out.cnt - 2'd1].last_of_run = 1'b1;
    end
  end

  assign state_next = accept ? w.st : state;
  assign bundle     = w.out;
  assign status     = '{first_pixel_pending: state.first_pixel_pending,
                        res_count: w.out.cnt};

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: src/brle_outq.sv
// Four-entry output queue: up to three in at once, one out a cycle if ready.
`timescale 1ns / 1ps

module brle_outq
  import brle_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  brle_bundle_t   bundle,
  brle_out_if.source     results,
  output brle_q_status_t status
);

  brle_res_t [Q_DEPTH-1:0] slot;
  brle_res_t [Q_DEPTH-1:0] slot_next;
  logic [Q_CNT_W-1:0]      count;
  logic [Q_CNT_W-1:0]      count_next;
  logic                    pop;
  logic [Q_CNT_W-1:0]      base;
  logic [Q_CNT_W-1:0]      off;
  logic [Q_CNT_W-1:0]      push_cnt;

  assign pop      = results.valid && results.ready;
  assign base     = count - Q_CNT_W'(pop);
  assign push_cnt = push ? Q_CNT_W'(bundle.cnt) : '0;

  // Shift out the head word, then write new words behind what is left
  always_comb begin
    off = '0;
    for (int j = 0; j < Q_DEPTH; j++) begin
      if (pop && (j < Q_DEPTH - 1)) begin
        slot_next[j] = slot[j + 1];
      end else begin
        slot_next[j] = slot[j];
      end
      off = Q_CNT_W'(j) - base;
      if ((Q_CNT_W'(j) >= base) && (off < push_cnt)) begin
        slot_next[j] = bundle.res[off[1:0]];
      end
    end
  end

  assign count_next = base + push_cnt;

  always_ff @(posedge clk) begin
    slot <= slot_next;
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign results.valid         = (count != '0);
  assign results.stream_select = slot[0].stream_select;
  assign results.out_byte      = slot[0].out_byte;
  assign results.last_of_run   = slot[0].last_of_run;

  // Room for a full bundle whatever the downstream does this cycle
  assign status = '{count: count, room: (count <= Q_CNT_W'(Q_DEPTH - MAX_RES))};

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the two-level bit-flag RLE compressor.
`timescale 1ns / 1ps

module testbench;
  import brle_pkg::*;

  typedef struct {
    logic [7:0] px;
    logic       eoi;
  } pix_word_t;

  logic clk;
  logic rst;

  brle_in_if  pixels_if ();
  brle_out_if results_if ();

  bitflag_rle_compressor DUT (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pixels_if),
    .results (results_if)
  );

  // Words still to send, and compressed bytes still to arrive
  pix_word_t pix_pending[$];
  brle_res_t comp_expected[$];
  brle_res_t step_res[$];

  int n_total;
  int n_taken;
  int n_errors;
  int in_gap;
  int out_gap;
  bit in_took;
  bit quiet;

  // Compressor state mirror
  logic       c_first_px;
  logic [7:0] c_prev_px;
  logic [7:0] c_flag_acc;
  logic [3:0] c_flag_pos;
  logic       c_first_flag;
  logic [7:0] c_prev_flag;
  logic [7:0] c_pts_acc;
  logic [3:0] c_pts_pos;

  task automatic clear_image();
    c_first_px   = 1'b1;
    c_prev_px    = 8'd0;
    c_flag_acc   = 8'd0;
    c_flag_pos   = POS_START;
    c_first_flag = 1'b1;
    c_prev_flag  = 8'd0;
    c_pts_acc    = 8'd0;
    c_pts_pos    = POS_START;
  endtask

  task automatic add_res(input logic [1:0] sel, input logic [7:0] b);
    brle_res_t r;
    r.stream_select = sel;
    r.out_byte      = b;
    r.last_of_run   = 1'b0;
    step_res.push_back(r);
  endtask

  // Second level: a finished flag byte against the one before
  task automatic close_flag_byte(input logic [7:0] f);
    if (c_first_flag) begin
      add_res(SEL_RLE, f);
      c_first_flag = 1'b0;
    end else begin
      c_pts_pos = c_pts_pos - 4'd1;
      if (f != c_prev_flag) begin
        add_res(SEL_RLE, f);
        c_pts_acc = c_pts_acc | (8'd1 << c_pts_pos[2:0]);
      end
      if (c_pts_pos == 4'd0) begin
        add_res(SEL_POINTS, c_pts_acc);
        c_pts_acc = 8'd0;
        c_pts_pos = POS_EMPTY;
      end
    end
    c_prev_flag = f;
  endtask

  // Expected compressed bytes for one accepted pixel word
  task automatic compress_word(input pix_word_t w);
    brle_res_t r;
    step_res.delete();
    if (c_first_px) begin
      add_res(SEL_DATA, w.px);
      c_first_px = 1'b0;
    end else begin
      c_flag_pos = c_flag_pos - 4'd1;
      if (w.px != c_prev_px) begin
        add_res(SEL_DATA, w.px);
        c_flag_acc = c_flag_acc | (8'd1 << c_flag_pos[2:0]);
      end
      if (c_flag_pos == 4'd0) begin
        close_flag_byte(c_flag_acc);
        c_flag_acc = 8'd0;
        c_flag_pos = POS_EMPTY;
      end
    end
    c_prev_px = w.px;
    // End of image: flush partial flag and points bytes
    if (w.eoi) begin
      if (c_flag_pos != POS_EMPTY) close_flag_byte(c_flag_acc);
      if (c_pts_pos != POS_EMPTY) add_res(SEL_POINTS, c_pts_acc);
      clear_image();
    end
    if (step_res.size() > 0) begin
      r = step_res[step_res.size() - 1];
      r.last_of_run = 1'b1;
      step_res[step_res.size() - 1] = r;
    end
    foreach (step_res[i]) comp_expected.push_back(step_res[i]);
  endtask

  task automatic add_word(input logic [7:0] px, input logic eoi);
    pix_word_t w;
    w.px  = px;
    w.eoi = eoi;
    pix_pending.push_back(w);
  endtask

  task automatic add_image(input logic [7:0] vals[$]);
    foreach (vals[i]) add_word(vals[i], i == vals.size() - 1);
  endtask

  // Random images: lengths and content shaped for repeats at both levels
  task automatic add_random_image(input bit last_one);
    int len;
    int sel;
    int mode;
    logic [7:0] cur;
    logic [7:0] pat[8];
    bit close;
    sel = $urandom_range(0, 9);
    if (sel < 2) len = $urandom_range(1, 8);
    else if (sel < 8) len = $urandom_range(9, 80);
    else len = $urandom_range(81, 160);
    mode = $urandom_range(0, 3);
    cur = 8'($urandom_range(0, 255));
    foreach (pat[k]) pat[k] = 8'($urandom_range(0, 255));
    close = last_one || ($urandom_range(0, 9) != 0);
    for (int i = 0; i < len; i++) begin
      case (mode)
        0: cur = 8'($urandom_range(0, 255));
        1: if ($urandom_range(0, 4) == 0) cur = 8'($urandom_range(0, 255));
        2: cur = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: begin
          if ($urandom_range(0, 9) == 0) pat[3'(i)] = 8'($urandom_range(0, 255));
          cur = pat[3'(i)];
        end
      endcase
      add_word(cur, close && (i == len - 1));
    end
  endtask

  task automatic report(input string what, input brle_res_t exp_r, input brle_res_t got_r);
    n_errors++;
    if (n_errors <= 10)
      $display({"%0t mismatch (%s): expected sel=%0d byte=%02h last=%0b,",
                " got sel=%0d byte=%02h last=%0b"},
               $realtime, what, exp_r.stream_select, exp_r.out_byte, exp_r.last_of_run,
               got_r.stream_select, got_r.out_byte, got_r.last_of_run);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Timeout
  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Pixel driver: holds each word until taken, random gaps between words
  always @(negedge clk) begin
    if (rst) begin
      pixels_if.valid <= 1'b0;
    end else if (pixels_if.valid && !in_took) begin
      // hold current word
    end else if (in_gap > 0) begin
      pixels_if.valid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (pix_pending.size() == 0) begin
      pixels_if.valid <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      pixels_if.valid <= 1'b0;
      in_gap <= $urandom_range(0, 6);
    end else begin
      pixels_if.valid        <= 1'b1;
      pixels_if.pixel_byte   <= pix_pending[0].px;
      pixels_if.end_of_image <= pix_pending[0].eoi;
    end
  end

  // Result sink: ready with random stall bursts
  always @(negedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
    end else if (out_gap > 0) begin
      results_if.ready <= 1'b0;
      out_gap <= out_gap - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      results_if.ready <= 1'b0;
      out_gap <= $urandom_range(0, 6);
    end else begin
      results_if.ready <= 1'b1;
    end
  end

  // Intake prediction and result check
  always @(posedge clk) begin
    brle_res_t got_r;
    brle_res_t exp_r;
    in_took = !rst && pixels_if.valid && pixels_if.ready;
    if (in_took) begin
      compress_word(pix_pending[0]);
      pix_pending.pop_front();
      n_taken++;
      quiet = (n_taken >= n_total - 60);
    end
    if (!rst && results_if.valid && results_if.ready) begin
      got_r.stream_select = results_if.stream_select;
      got_r.out_byte      = results_if.out_byte;
      got_r.last_of_run   = results_if.last_of_run;
      if (comp_expected.size() == 0) begin
        exp_r = '0;
        report("unexpected word", exp_r, got_r);
      end else begin
        exp_r = comp_expected.pop_front();
        if (got_r.stream_select !== exp_r.stream_select) report("stream_select", exp_r, got_r);
        else if (got_r.out_byte !== exp_r.out_byte) report("out_byte", exp_r, got_r);
        else if (got_r.last_of_run !== exp_r.last_of_run) report("last_of_run", exp_r, got_r);
      end
    end
  end

  // Stimulus and end of run
  initial begin
    n_taken  = 0;
    n_errors = 0;
    in_gap   = 0;
    out_gap  = 0;
    in_took  = 1'b0;
    quiet    = 1'b0;
    clear_image();
    rst = 1'b1;
    pixels_if.valid        = 1'b0;
    pixels_if.pixel_byte   = 8'd0;
    pixels_if.end_of_image = 1'b0;
    results_if.ready       = 1'b0;

    // Single-byte images at both extremes
    add_image('{8'h00});
    add_image('{8'hFF});
    // Repeats, extremes and one full flag byte
    add_image('{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h01, 8'h80, 8'h80, 8'h7F, 8'h7F});
    // All-equal image: flag bytes of zero
    add_image('{8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A});
    add_image('{8'hA5, 8'h3C});
    while (pix_pending.size() < 320) add_random_image(1'b0);
    add_random_image(1'b1);
    n_total = pix_pending.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pix_pending.size() != 0 || comp_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (comp_expected.size() != 0) begin
      n_errors++;
      $display("%0d expected words never arrived", comp_expected.size());
    end
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
src/brle_pkg.sv
src/brle_in_if.sv
src/brle_out_if.sv
src/brle_core.sv
src/brle_outq.sv
src/bitflag_rle_compressor.sv
dv/testbench.sv
